[hw/rtl/sdf_pkg.sv]
// ----------------------------------------------------------------------------
// sdf_pkg
// shared widths, character codes and stage types of the decimal formatter
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int ValueWidth  = 32;
    localparam int NumDigits   = 10;
    localparam int BcdWidth    = 4 * NumDigits;
    localparam int CharWidth   = 8;
    localparam int BitsPerStep = 8;
    localparam int NumSteps    = ValueWidth / BitsPerStep;

    localparam logic [CharWidth-1:0] ChZero  = 8'h30;
    localparam logic [CharWidth-1:0] ChMinus = 8'h2d;
    localparam logic [CharWidth-1:0] ChSpace = 8'h20;

    // prefix kind carried with the digits
    typedef enum logic [1:0] {
        PFX_NONE  = 2'd0,
        PFX_MINUS = 2'd1,
        PFX_SPACE = 2'd2,
        PFX_ERR   = 2'd3
    } prefix_t;

    // one word in flight through the conversion stages
    typedef struct packed {
        logic [ValueWidth-1:0] mag;
        logic [BcdWidth-1:0]   bcd;
        prefix_t               prefix;
    } conv_t;

    // one double-dabble step: add three to every digit at five or above, shift in a bit
    function automatic logic [BcdWidth-1:0] dabble(input logic [BcdWidth-1:0] b,
                                                   input logic in_bit);
        logic [BcdWidth-1:0] t;
        t = b;
        for (int d = 0; d < NumDigits; d++) begin
            if (t[4*d +: 4] >= 4'd5) begin
                t[4*d +: 4] = t[4*d +: 4] + 4'd3;
            end
        end
        return {t[BcdWidth-2:0], in_bit};
    endfunction

endpackage

[hw/rtl/signed_decimal_formatter_core.sv]
// ----------------------------------------------------------------------------
// signed_decimal_formatter_core
// signed 32-bit integer to decimal ascii text, one character per word
// ----------------------------------------------------------------------------
// A number enters, passes an input register and four conversion stages of
// eight double-dabble steps each, then sits in the character emitter, which
// sends one character per cycle while the receiver is ready (1 to 11 per
// number) and takes the next number on the cycle it sends the last one.
// Throughput is set by the emitter. Short flag with an out of range value
// gives "-1".
module signed_decimal_formatter_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sdf_pkg::ValueWidth-1:0] s_tdata,  // value[31:0]
    input  logic [1:0]                    s_tuser,   // short_flag, space_flag
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sdf_pkg::CharWidth-1:0] m_tdata,   // character[7:0]
    output logic                          m_tlast
);
    import sdf_pkg::*;

    logic  en;
    logic  emit_ready;
    logic  v0_reg;
    conv_t w0_reg;
    conv_t w0_next;
    logic  [NumSteps:0] vld;
    conv_t wrd [NumSteps+1];
    logic  [ValueWidth-1:0] biased;
    logic  neg;

    assign neg    = s_tdata[ValueWidth-1];
    assign biased = s_tdata + 32'h0000_8000;

    always_comb begin
        w0_next.bcd = '0;
        if (s_tuser[1] && biased[ValueWidth-1:16] != '0) begin
            w0_next.prefix = PFX_ERR;
            w0_next.mag    = '0;
        end else if (neg) begin
            w0_next.prefix = PFX_MINUS;
            w0_next.mag    = -s_tdata;
        end else begin
            w0_next.prefix = s_tuser[0] ? PFX_SPACE : PFX_NONE;
            w0_next.mag    = s_tdata;
        end
    end

    // whole pipe advances when the emitter can take, or the tail is empty
    assign en       = emit_ready || !vld[NumSteps];
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w0_reg <= w0_next;
        end
    end

    assign vld[0] = v0_reg;
    assign wrd[0] = w0_reg;

    for (genvar g = 0; g < NumSteps; g++) begin : g_conv
        sdf_conv_stage u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (vld[g]),
            .in_word  (wrd[g]),
            .out_valid(vld[g+1]),
            .out_word (wrd[g+1])
        );
    end

    sdf_emitter u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(vld[NumSteps]),
        .in_ready(emit_ready),
        .in_word (wrd[NumSteps]),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // emitted character is always a digit, minus or space
    a_char_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata >= ChZero && m_tdata <= 8'h39) ||
                      m_tdata == ChMinus || m_tdata == ChSpace))
        else $error("bad character");

    // a stalled character holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed under stall");

    // a stall at the tail freezes the pipe
    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        vld[NumSteps] && !emit_ready |-> !s_tready)
        else $error("pipe advanced into busy emitter");
endmodule

[hw/rtl/sdf_conv_stage.sv]
// ----------------------------------------------------------------------------
// sdf_conv_stage
// one pipeline stage of binary to bcd conversion, eight bits per stage
// ----------------------------------------------------------------------------
module sdf_conv_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  sdf_pkg::conv_t in_word,
    output logic           out_valid,
    output sdf_pkg::conv_t out_word
);
    import sdf_pkg::*;

    logic  valid_reg;
    conv_t word_reg;
    conv_t word_next;

    always_comb begin
        word_next = in_word;
        for (int i = 0; i < BitsPerStep; i++) begin
            word_next.bcd = dabble(word_next.bcd, word_next.mag[ValueWidth-1]);
            word_next.mag = {word_next.mag[ValueWidth-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
endmodule

[hw/rtl/sdf_emitter.sv]
// ----------------------------------------------------------------------------
// sdf_emitter
// holds one converted number and streams its characters out
// ----------------------------------------------------------------------------
module sdf_emitter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  sdf_pkg::conv_t                 in_word,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sdf_pkg::CharWidth-1:0]  m_tdata,
    output logic                           m_tlast
);
    import sdf_pkg::*;

    localparam int IdxWidth = $clog2(NumDigits + 1);

    logic                busy_reg;
    logic                pfx_pend_reg;
    logic [CharWidth-1:0] pfx_char_reg;
    logic [BcdWidth-1:0] bcd_reg;
    logic [IdxWidth-1:0] idx_reg;     // digit being sent, counted from the top
    logic                err_reg;
    logic [IdxWidth-1:0] first_idx;
    logic [3:0]          cur_digit;
    logic                is_last;

    // find the leading nonzero digit; zero keeps the lowest one
    always_comb begin
        first_idx = IdxWidth'(NumDigits - 1);
        for (int d = 0; d < NumDigits; d++) begin
            if (in_word.bcd[4*d +: 4] != 4'd0) begin
                first_idx = IdxWidth'(NumDigits - 1 - d);
            end
        end
    end

    assign cur_digit = err_reg ? 4'd1 : bcd_reg[BcdWidth-1 -: 4];
    assign is_last   = !pfx_pend_reg && (err_reg || idx_reg == IdxWidth'(NumDigits - 1));
    assign in_ready  = !busy_reg || (m_tready && is_last);
    assign m_tvalid  = busy_reg;
    assign m_tdata   = pfx_pend_reg ? pfx_char_reg : (ChZero | {4'd0, cur_digit});
    assign m_tlast   = is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            busy_reg <= 1'b1;
        end else if (m_tready && is_last) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            err_reg      <= in_word.prefix == PFX_ERR;
            pfx_pend_reg <= in_word.prefix != PFX_NONE;
            pfx_char_reg <= (in_word.prefix == PFX_SPACE) ? ChSpace : ChMinus;
            idx_reg      <= first_idx;
            bcd_reg      <= in_word.bcd << (4 * first_idx);
        end else if (busy_reg && m_tready) begin
            if (pfx_pend_reg) begin
                pfx_pend_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
                bcd_reg <= {bcd_reg[BcdWidth-5:0], 4'd0};
            end
        end
    end
endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// drives signed integers with space and short flags into the decimal formatter
// and checks every character word against a local formatter model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import sdf_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [ValueWidth-1:0] s_tdata = '0;
    logic [1:0]            s_tuser = '0;  // short_flag, space_flag
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [CharWidth-1:0]  m_tdata;       // character[7:0]
    logic                  m_tlast;

    typedef struct packed {
        logic [CharWidth-1:0] ch;
        logic                 last;
    } text_char_t;

    text_char_t exp_chars[$];
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         recv_hold = 1'b0;
    int         hold_cycles = 0;

    signed_decimal_formatter_core u_dut (.*);

    always #1 aclk = ~aclk;

    // expected text of one number
    task automatic format_number(input logic [31:0] v, input bit sp, input bit sh);
        logic [31:0] mag;
        logic [3:0]  dig[10];
        int          nd;
        nd = 0;
        if (sh && (v + 32'h8000) >= 32'h10000) begin
            exp_chars.push_back('{ChMinus, 1'b0});
            exp_chars.push_back('{ChZero + 8'd1, 1'b1});
        end else begin
            if (v[31]) begin
                exp_chars.push_back('{ChMinus, 1'b0});
                mag = 32'd0 - v;
            end else begin
                if (sp) exp_chars.push_back('{ChSpace, 1'b0});
                mag = v;
            end
            do begin
                dig[nd] = 4'(mag % 10);
                mag = mag / 10;
                nd++;
            end while (mag != 0 && nd < 10);
            for (int i = nd - 1; i >= 0; i--)
                exp_chars.push_back('{ChZero + 8'(dig[i]), i == 0});
        end
    endtask

    task automatic send_number(input logic [31:0] v, input bit sp, input bit sh);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = v;
        s_tuser  = {sh, sp};
        format_number(v, sp, sh);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (exp_chars.size() != 0) @(negedge aclk);
    endtask

    // receiver stall pattern
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        text_char_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h last %b", m_tdata, m_tlast);
            end else begin
                e = exp_chars.pop_front();
                if (e.ch !== m_tdata || e.last !== m_tlast) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: exp %h/%b got %h/%b",
                                 e.ch, e.last, m_tdata, m_tlast);
                end
            end
        end
    end

    task automatic test_directed();
        logic [31:0] vals[12] = '{32'd0, 32'd1, 32'hffffffff, 32'd9, 32'd10,
                                  32'h7fffffff, 32'h80000000, 32'd32767,
                                  32'hffff8000, 32'd32768, 32'hffff7fff, 32'd1000000000};
        foreach (vals[i]) begin
            send_number(vals[i], i[0], i[1]);
            if (i < 8) send_number(vals[i], ~i[0], ~i[1]);
        end
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed(16'($urandom)));
            2: return 32'($urandom_range(20)) - 32'd10;
            default: return 32'($urandom_range(70000)) - 32'd35000;
        endcase
    endfunction

    task automatic test_random(input int n);
        repeat (n) send_number(rand_value(), $urandom_range(1), $urandom_range(1));
    endtask

    task automatic test_backpressure();
        wait_drained();
        @(negedge aclk);
        hold_cycles = 200;
        test_random(20);
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 11;
        recv_idle_pct = 70;
        test_directed();
        test_random(90);
        test_backpressure();
        send_idle_pct = 70;
        recv_idle_pct = 11;
        test_random(90);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(90);
        wait_drained();
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && exp_chars.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sdf_pkg.sv
hw/rtl/sdf_conv_stage.sv
hw/rtl/sdf_emitter.sv
hw/rtl/signed_decimal_formatter_core.sv
dv/tb.sv
